/* rtl/rotenc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotenc_pkg: shared types and constants of the rotary encoder front end
// Register map, item codes, configuration and result structures.
// ----------------------------------------------------------------------------
package rotenc_pkg;

  // default counter width
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int GUARD_W  = 16;
  localparam int FILT_W   = 7;
  localparam int WIN_W    = 16;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  // item codes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  // register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GUARD_TICKS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FILT_TICKS  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DBL_WINDOW  = 3'd6;

  // register reset values
  localparam logic [DATA_W-1:0]  RST_STEP_SIZE   = 32'h0000_0001;
  localparam logic [DATA_W-1:0]  RST_UPPER_LIMIT = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]  RST_LOWER_LIMIT = 32'h8000_0000;
  localparam logic               RST_WRAP_ENABLE = 1'b0;
  localparam logic [GUARD_W-1:0] RST_GUARD_TICKS = 16'd10;
  localparam logic [FILT_W-1:0]  RST_FILT_TICKS  = 7'd10;
  localparam logic [WIN_W-1:0]   RST_DBL_WINDOW  = 16'd50;

  // configuration seen by the core
  typedef struct packed {
    logic [DATA_W-1:0]  step_size;
    logic [DATA_W-1:0]  upper_limit;
    logic [DATA_W-1:0]  lower_limit;
    logic               wrap_enable;
    logic [GUARD_W-1:0] reversal_guard_ticks;
    logic [FILT_W-1:0]  switch_filter_ticks;
    logic [WIN_W-1:0]   double_push_window;
  } cfg_t;

  // event flags of one result
  typedef struct packed {
    logic rotated_up;
    logic rotated_down;
    logic hit_maximum;
    logic hit_minimum;
    logic button_pushed;
    logic button_released;
    logic button_double_pushed;
    logic interrupt_pulse;
  } flags_t;

  // one result beat
  typedef struct packed {
    logic [DATA_W-1:0] counter_value;
    flags_t            flags;
  } result_t;

endpackage

/* rtl/rotenc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotenc_core: counter, reversal guard, debouncer and button machine
// Holds the block state and the result register; one item per load.
// ----------------------------------------------------------------------------
module rotenc_core #(
  parameter int VALUE_WIDTH = rotenc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [1:0]          mode,
  input  logic                switch_pressed,
  input  rotenc_pkg::cfg_t    cfg,
  output rotenc_pkg::result_t res
);

  typedef enum logic [2:0] {
    BS_WAITPUSH           = 3'd0,
    BS_WAITRELEASE        = 3'd1,
    BS_WAITDOUBLEPUSH     = 3'd2,
    BS_WAITDOUBLERELEASED = 3'd3,
    BS_TIMEOUT            = 3'd4,
    BS_PUSHRESET          = 3'd5
  } btn_state_t;

  localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [VALUE_WIDTH-1:0]          cnt_r, cnt_nxt;
  logic                                   dir_r, dir_nxt;
  logic [rotenc_pkg::GUARD_W-1:0]         guard_r, guard_nxt;
  logic [rotenc_pkg::FILT_W-1:0]          integ_r, integ_nxt;
  logic                                   filt_r, filt_nxt;
  btn_state_t                             btn_r, btn_nxt, btn_sel;
  logic [rotenc_pkg::WIN_W-1:0]           win_r, win_nxt;
  rotenc_pkg::result_t                    res_r;
  rotenc_pkg::flags_t                     flags;

  logic signed [VALUE_WIDTH-1:0]          step_s, hi_s, lo_s;
  logic signed [VALUE_WIDTH:0]            sum, sum_lim;
  logic                                   down, drop;

  // configured values in the counter width
  assign step_s = signed'(cfg.step_size[VALUE_WIDTH-1:0]);
  assign hi_s   = signed'(cfg.upper_limit[VALUE_WIDTH-1:0]);
  assign lo_s   = signed'(cfg.lower_limit[VALUE_WIDTH-1:0]);

  // widened add or subtract and limit handling
  assign down = (mode == rotenc_pkg::MODE_DOWN);
  assign drop = (dir_r != down) && (guard_r < cfg.reversal_guard_ticks);

  always_comb begin
    logic crossed;
    crossed = 1'b0;
    if (!down) begin
      sum = (VALUE_WIDTH+1)'(cnt_r) + (VALUE_WIDTH+1)'(step_s);
      crossed = (sum > (VALUE_WIDTH+1)'(hi_s));
    end else begin
      sum = (VALUE_WIDTH+1)'(cnt_r) - (VALUE_WIDTH+1)'(step_s);
      crossed = (sum < (VALUE_WIDTH+1)'(lo_s));
    end
    sum_lim = sum;
    if (crossed) begin
      if (cfg.wrap_enable) begin
        sum_lim = down ? (VALUE_WIDTH+1)'(hi_s) : (VALUE_WIDTH+1)'(lo_s);
      end else begin
        sum_lim = down ? (VALUE_WIDTH+1)'(lo_s) : (VALUE_WIDTH+1)'(hi_s);
      end
    end
  end

  // next state for one item
  always_comb begin
    cnt_nxt   = cnt_r;
    dir_nxt   = dir_r;
    guard_nxt = guard_r;
    integ_nxt = integ_r;
    filt_nxt  = filt_r;
    btn_nxt   = btn_r;
    btn_sel   = btn_r;
    win_nxt   = win_r;
    flags     = '0;
    unique case (mode)
      rotenc_pkg::MODE_TICK: begin
        // reversal guard
        if (guard_r < cfg.reversal_guard_ticks) begin
          guard_nxt = guard_r + 1'b1;
        end
        // integrating debouncer
        if (switch_pressed) begin
          if (integ_r >= cfg.switch_filter_ticks) begin
            integ_nxt = cfg.switch_filter_ticks;
            filt_nxt  = 1'b1;
          end else begin
            integ_nxt = integ_r + 1'b1;
          end
        end else begin
          if (integ_r == '0) begin
            filt_nxt = 1'b0;
          end else begin
            integ_nxt = integ_r - 1'b1;
          end
        end
        // double push window
        if (win_r > cfg.double_push_window) begin
          btn_sel = BS_TIMEOUT;
        end else if (win_r != '1) begin
          win_nxt = win_r + 1'b1;
        end
        btn_nxt = btn_sel;
        // button machine
        case (btn_sel)
          BS_WAITRELEASE: begin
            if (!filt_nxt) btn_nxt = BS_WAITDOUBLEPUSH;
          end
          BS_WAITDOUBLEPUSH: begin
            if (filt_nxt) btn_nxt = BS_WAITDOUBLERELEASED;
          end
          BS_WAITDOUBLERELEASED: begin
            if (!filt_nxt) begin
              win_nxt                    = '0;
              btn_nxt                    = BS_WAITPUSH;
              flags.button_double_pushed = 1'b1;
              flags.interrupt_pulse      = 1'b1;
            end
          end
          BS_TIMEOUT: begin
            win_nxt             = '0;
            flags.button_pushed = 1'b1;
            if (filt_nxt) begin
              btn_nxt = BS_PUSHRESET;
            end else begin
              btn_nxt               = BS_WAITPUSH;
              flags.button_released = 1'b1;
            end
            flags.interrupt_pulse = 1'b1;
          end
          BS_PUSHRESET: begin
            win_nxt = '0;
            if (!filt_nxt) begin
              btn_nxt               = BS_WAITPUSH;
              flags.button_released = 1'b1;
              flags.interrupt_pulse = 1'b1;
            end
          end
          default: begin
            win_nxt = '0;
            btn_nxt = filt_nxt ? BS_WAITRELEASE : BS_WAITPUSH;
          end
        endcase
      end
      rotenc_pkg::MODE_UP, rotenc_pkg::MODE_DOWN: begin
        if (!drop) begin
          guard_nxt = '0;
          dir_nxt   = down;
          // saturate to the counter range
          if (sum_lim[VALUE_WIDTH] != sum_lim[VALUE_WIDTH-1]) begin
            cnt_nxt = sum_lim[VALUE_WIDTH] ? VMIN : VMAX;
          end else begin
            cnt_nxt = sum_lim[VALUE_WIDTH-1:0];
          end
          flags.rotated_up      = !down;
          flags.rotated_down    = down;
          flags.hit_maximum     = !down && (sum > (VALUE_WIDTH+1)'(hi_s));
          flags.hit_minimum     = down && (sum < (VALUE_WIDTH+1)'(lo_s));
          flags.interrupt_pulse = 1'b1;
        end
      end
      default: begin
        // unused code: nothing changes
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      dir_r   <= 1'b0;
      guard_r <= '0;
      integ_r <= '0;
      filt_r  <= 1'b0;
      btn_r   <= BS_WAITPUSH;
      win_r   <= '0;
    end else if (load) begin
      cnt_r               <= cnt_nxt;
      dir_r               <= dir_nxt;
      guard_r             <= guard_nxt;
      integ_r             <= integ_nxt;
      filt_r              <= filt_nxt;
      btn_r               <= btn_nxt;
      win_r               <= win_nxt;
      res_r.counter_value <= rotenc_pkg::DATA_W'(cnt_nxt);
      res_r.flags         <= flags;
    end
  end

  assign res = res_r;

endmodule

/* rtl/rotary_encoder_button_front_end_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_front_end_top: encoder counter with push-button decoder
// Register file, input register and result handshake around the core.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_mode, in_switch_pressed
//  out      output     out_valid / out_stall  out_counter_value, event flags
//  config   input      APB r/w, pready = 1    psel, penable, pwrite, paddr, pwdata
//
//  One beat per cycle sustained while out_stall is low; an accepted input beat
//  enters the input register and then the result register as its result beat.
//  The rate is set by the counter feedback: one widened add and limit compare.
//  rst_n is synchronous: counter, guard, debouncer and button machine clear.
//  A stalled output holds its beat; the input register keeps accepting as long
//  as the beat ahead of it can move on.
// ----------------------------------------------------------------------------
module rotary_encoder_button_front_end_top #(
  parameter int VALUE_WIDTH = rotenc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic                              in_switch_pressed,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rotenc_pkg::DATA_W-1:0] out_counter_value,
  output logic                              out_rotated_up,
  output logic                              out_rotated_down,
  output logic                              out_hit_maximum,
  output logic                              out_hit_minimum,
  output logic                              out_button_pushed,
  output logic                              out_button_released,
  output logic                              out_button_double_pushed,
  output logic                              out_interrupt_pulse,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rotenc_pkg::ADDR_W-1:0]     paddr,
  input  logic [rotenc_pkg::DATA_W-1:0]     pwdata,
  output logic [rotenc_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);

  rotenc_pkg::cfg_t                   cfg_r;
  logic [rotenc_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                               cfg_wr;

  logic                               in_valid_r;
  logic [1:0]                         in_mode_r;
  logic                               in_sw_r;
  logic                               out_valid_r;
  logic                               core_load;
  rotenc_pkg::result_t                res;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[rotenc_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size            <= rotenc_pkg::RST_STEP_SIZE;
      cfg_r.upper_limit          <= rotenc_pkg::RST_UPPER_LIMIT;
      cfg_r.lower_limit          <= rotenc_pkg::RST_LOWER_LIMIT;
      cfg_r.wrap_enable          <= rotenc_pkg::RST_WRAP_ENABLE;
      cfg_r.reversal_guard_ticks <= rotenc_pkg::RST_GUARD_TICKS;
      cfg_r.switch_filter_ticks  <= rotenc_pkg::RST_FILT_TICKS;
      cfg_r.double_push_window   <= rotenc_pkg::RST_DBL_WINDOW;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rotenc_pkg::REG_STEP_SIZE:   cfg_r.step_size   <= pwdata;
        rotenc_pkg::REG_UPPER_LIMIT: cfg_r.upper_limit <= pwdata;
        rotenc_pkg::REG_LOWER_LIMIT: cfg_r.lower_limit <= pwdata;
        rotenc_pkg::REG_WRAP_ENABLE: cfg_r.wrap_enable <= pwdata[0];
        rotenc_pkg::REG_GUARD_TICKS: begin
          cfg_r.reversal_guard_ticks <= pwdata[rotenc_pkg::GUARD_W-1:0];
        end
        rotenc_pkg::REG_FILT_TICKS: begin
          cfg_r.switch_filter_ticks <= pwdata[rotenc_pkg::FILT_W-1:0];
        end
        rotenc_pkg::REG_DBL_WINDOW: begin
          cfg_r.double_push_window <= pwdata[rotenc_pkg::WIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      rotenc_pkg::REG_STEP_SIZE:   prdata = cfg_r.step_size;
      rotenc_pkg::REG_UPPER_LIMIT: prdata = cfg_r.upper_limit;
      rotenc_pkg::REG_LOWER_LIMIT: prdata = cfg_r.lower_limit;
      rotenc_pkg::REG_WRAP_ENABLE: prdata = rotenc_pkg::DATA_W'(cfg_r.wrap_enable);
      rotenc_pkg::REG_GUARD_TICKS: prdata = rotenc_pkg::DATA_W'(cfg_r.reversal_guard_ticks);
      rotenc_pkg::REG_FILT_TICKS:  prdata = rotenc_pkg::DATA_W'(cfg_r.switch_filter_ticks);
      rotenc_pkg::REG_DBL_WINDOW:  prdata = rotenc_pkg::DATA_W'(cfg_r.double_push_window);
      default:                     prdata = '0;
    endcase
  end

  // flow control: the core runs when the held beat can enter the result register
  assign core_load = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !core_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_mode_r <= in_mode;
      in_sw_r   <= in_switch_pressed;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  rotenc_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (core_load),
    .mode           (in_mode_r),
    .switch_pressed (in_sw_r),
    .cfg            (cfg_r),
    .res            (res)
  );

  // result ports
  assign out_valid                = out_valid_r;
  assign out_counter_value        = signed'(res.counter_value);
  assign out_rotated_up           = res.flags.rotated_up;
  assign out_rotated_down         = res.flags.rotated_down;
  assign out_hit_maximum          = res.flags.hit_maximum;
  assign out_hit_minimum          = res.flags.hit_minimum;
  assign out_button_pushed        = res.flags.button_pushed;
  assign out_button_released      = res.flags.button_released;
  assign out_button_double_pushed = res.flags.button_double_pushed;
  assign out_interrupt_pulse      = res.flags.interrupt_pulse;

endmodule
